>>> sv/gtm_pkg.sv
// shared types, constants and tables of the global tone mapper
package gtm_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int MAX_PIXELS_LOG2 = 24;
   localparam int PIX_FRAC        = 16;

   localparam int PIX_W   = 24;
   localparam int LUM_W   = 24;
   localparam int KEY_W   = 16;
   localparam int WP_W    = 24;
   localparam int BOFF_W  = 16;
   localparam int CSR_W   = 24;
   localparam int CSR_IW  = 2;
   localparam int OUT_W   = 16;
   localparam int SUM_W   = 48;
   localparam int CNT_W   = MAX_PIXELS_LOG2 + 1;
   localparam int SCALE_W = 32;
   localparam int LOGX_W  = 25;
   localparam int LOG_IW  = 6;
   localparam int LOG_W   = LOG_IW + FRAC_BITS;
   localparam int DVD_W   = 64;
   localparam int DVS_W   = 48;
   localparam int LD_W    = 45;
   localparam int LD_SAT  = 40;
   localparam int IT_W    = $clog2(FRAC_BITS);

   localparam logic [15:0] WEIGHT_R = 16'd19595;
   localparam logic [15:0] WEIGHT_G = 16'd38470;
   localparam logic [15:0] WEIGHT_B = 16'd7471;

   localparam logic [KEY_W-1:0]  KEY_RESET   = 16'd11796;
   localparam logic [WP_W-1:0]   WHITE_RESET = 24'd117965;
   localparam logic [BOFF_W-1:0] BLACK_RESET = 16'd6554;

   // register indexes of the control port
   localparam logic [CSR_IW-1:0] CSR_KEY   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_WHITE = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_BLACK = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef struct packed {
      logic             done;
      logic [OUT_W-1:0] value;
   } lane_res_type;

   typedef logic [FRAC_BITS-1:0][31:0] base_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bv;
      logic [63:0] rem;
      res = '0;
      rem = v;
      bv  = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (bv > rem) bv = bv >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bv != 0) begin
            if (rem >= res + bv) begin
               rem = rem - (res + bv);
               res = (res >> 1) + bv;
            end else begin
               res = res >> 1;
            end
            bv = bv >> 2;
         end
      end
      return res;
   endfunction

   // successive square roots of 2 in Q2.30, one per fraction bit
   function automatic base_tab_type exp_bases();
      base_tab_type t;
      logic [63:0]  b;
      b = 64'h8000_0000;
      for (int k = 0; k < FRAC_BITS; k++) begin
         b    = isqrt64(b << 30);
         t[k] = b[31:0];
      end
      return t;
   endfunction

   localparam base_tab_type EXP_BASE = exp_bases();

endpackage

>>> sv/global_tone_mapper_unit.sv
// global tone mapper top level: measure pass statistics and map pass pixel pipeline
// one request at a time; a measure request runs luma, normalize and 16 squarings,
// plus a mean divide and 16 root-power steps on the frame's last pixel; a map
// request runs three serial divides (t1, white ratio, then the three colour lanes
// in parallel)
// reset is synchronous: registers go to defaults, statistics and scale go to zero
module global_tone_mapper_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [71:0]                req_tdata,  // red, green, blue
   input  logic                       req_tuser,  // action
   input  logic                       req_tlast,  // last
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [47:0]                rsp_tdata,  // red_out, green_out, blue_out
   input  logic                       csr_we,
   input  logic [gtm_pkg::CSR_IW-1:0] csr_index,
   input  logic [gtm_pkg::CSR_W-1:0]  csr_wdata
);
   import gtm_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_LUM   = 16'h0002,
      S_LOG   = 16'h0004,
      S_ACC   = 16'h0008,
      S_MEAN  = 16'h0010,
      S_MDIV  = 16'h0020,
      S_EXP   = 16'h0040,
      S_KEY   = 16'h0080,
      S_SCALE = 16'h0100,
      S_LO    = 16'h0200,
      S_W2    = 16'h0400,
      S_T1    = 16'h0800,
      S_RAT   = 16'h1000,
      S_LD    = 16'h2000,
      S_LANE  = 16'h4000,
      S_OUT   = 16'h8000
   } state_type;

   localparam logic [IT_W-1:0] IT_LAST = IT_W'(FRAC_BITS - 1);
   localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}});
   localparam logic signed [SUM_W:0] SUM_MIN = -SUM_MAX - 1;
   localparam logic [DVD_W-1:0] RATIO_MAX = DVD_W'(1) << (LD_W - 1);

   // control state
   state_type state_ff, state_in;
   logic      div_go_ff, div_go_in;
   logic      log_go_ff, log_go_in;
   logic      lane_go_ff, lane_go_in;
   logic      rsp_valid_ff;
   logic      load_rsp;

   // configuration
   logic [KEY_W-1:0]  key_ff;
   logic [WP_W-1:0]   wp_ff;
   logic [BOFF_W-1:0] boff_ff;

   // statistics and scale
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SCALE_W-1:0]      scale_ff, scale_in;

   // request payload and working values
   logic                 act_ff, last_ff;
   logic [PIX_W-1:0]     r_ff, g_ff, b_ff;
   logic [40:0]          acc_ff, acc_in, acc_sum;
   logic [39:0]          wprod;
   logic [IT_W-1:0]      it_ff, it_in;
   logic [LUM_W-1:0]     lum_ff, lum_in;
   logic                 neg_ff, neg_in;
   logic signed [SUM_W:0] n_ff, n_in;
   logic [31:0]          rpow_ff, rpow_in;
   logic [63:0]          rmul;
   logic [47:0]          kprod_ff, kprod_in;
   logic [39:0]          lo_ff, lo_in;
   logic [31:0]          w2_ff, w2_in;
   logic [15:0]          t1_ff, t1_in;
   logic [LD_W-1:0]      ratio_ff, ratio_in, ld_ff, ld_in;
   logic [DVD_W-1:0]     num_ff, num_in;
   logic [DVS_W-1:0]     den_ff, den_in;
   logic [47:0]          res_ff, res_in;

   // arithmetic helpers
   logic signed [SUM_W:0] sum_add, sum_abs_src;
   logic [SUM_W-1:0]      sum_mag;
   logic signed [SUM_W:0] ip, sh;
   logic [47:0]           shifted;
   logic [55:0]           lo_full;
   logic [47:0]           wsq;
   logic [60:0]           ld_full;

   unit_stat_type           div_stat, log_stat;
   logic [DVD_W-1:0]        quo;
   logic signed [LOG_W-1:0] lg;
   lane_res_type            lane_r, lane_g, lane_b;
   logic                    lanes_done;

   // shared divider: frame mean, t1 and white ratio
   gtm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (num_ff),
      .divisor  (den_ff),
      .stat     (div_stat),
      .quotient (quo)
   );

   gtm_log u_log (
      .clock (clock),
      .reset (reset),
      .start (log_go_ff),
      .x     (LOGX_W'(lum_ff) + LOGX_W'(boff_ff)),
      .stat  (log_stat),
      .lg    (lg)
   );

   // three colour lanes work side by side
   gtm_lane u_lane_r (
      .clock (clock), .reset (reset), .start (lane_go_ff),
      .comp  (r_ff), .ld (ld_ff), .lum (lum_ff), .res (lane_r)
   );
   gtm_lane u_lane_g (
      .clock (clock), .reset (reset), .start (lane_go_ff),
      .comp  (g_ff), .ld (ld_ff), .lum (lum_ff), .res (lane_g)
   );
   gtm_lane u_lane_b (
      .clock (clock), .reset (reset), .start (lane_go_ff),
      .comp  (b_ff), .ld (ld_ff), .lum (lum_ff), .res (lane_b)
   );

   // lane done flags are stale in the cycle the start pulse is out
   assign lanes_done = !lane_go_ff && lane_r.done && lane_g.done && lane_b.done;

   // luma: one weighted component per cycle
   always_comb begin
      case (it_ff)
         IT_W'(0): wprod = 40'(WEIGHT_R) * 40'(r_ff);
         IT_W'(1): wprod = 40'(WEIGHT_G) * 40'(g_ff);
         default:  wprod = 40'(WEIGHT_B) * 40'(b_ff);
      endcase
   end
   assign acc_sum = acc_ff + 41'(wprod);

   // saturating log sum
   assign sum_add = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(lg);

   assign sum_abs_src = (SUM_W+1)'(sum_ff);
   assign sum_mag     = sum_ff[SUM_W-1] ? SUM_W'(-sum_abs_src) : SUM_W'(sum_abs_src);

   assign rmul    = 64'(rpow_ff) * 64'(EXP_BASE[it_ff]);
   assign ip      = n_ff >>> FRAC_BITS;
   assign sh      = (SUM_W+1)'(30) - ip;
   assign shifted = kprod_ff >> sh[5:0];
   assign lo_full = 56'(scale_ff) * 56'(lum_ff);
   assign wsq     = 48'(wp_ff) * 48'(wp_ff);
   assign ld_full = 61'(t1_ff) * 61'(LD_W'(65536) + ratio_ff);

   assign load_rsp = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      div_go_in  = 1'b0;
      log_go_in  = 1'b0;
      lane_go_in = 1'b0;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      scale_in   = scale_ff;
      acc_in     = acc_ff;
      it_in      = it_ff;
      lum_in     = lum_ff;
      neg_in     = neg_ff;
      n_in       = n_ff;
      rpow_in    = rpow_ff;
      kprod_in   = kprod_ff;
      lo_in      = lo_ff;
      w2_in      = w2_ff;
      t1_in      = t1_ff;
      ratio_in   = ratio_ff;
      ld_in      = ld_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      res_in     = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_LUM;
               acc_in   = 41'd32768;
               it_in    = '0;
            end
         end
         S_LUM: begin
            acc_in = acc_sum;
            it_in  = it_ff + 1'b1;
            if (it_ff == IT_W'(2)) begin
               lum_in = acc_sum[39:16];
               if (!act_ff) begin
                  // measure: add the log, or if the frame is too long, skip the sum but still honor last
                  if (!cnt_ff[MAX_PIXELS_LOG2]) begin
                     state_in  = S_LOG;
                     log_go_in = 1'b1;
                  end else if (last_ff) begin
                     state_in = S_MEAN;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else if (acc_sum[39:16] == '0) begin
                  // zero luminance maps to black
                  res_in   = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_LO;
               end
            end
         end
         S_LOG: begin
            if (log_stat.done) state_in = S_ACC;
         end
         S_ACC: begin
            if (sum_add > SUM_MAX)      sum_in = SUM_W'(SUM_MAX);
            else if (sum_add < SUM_MIN) sum_in = SUM_W'(SUM_MIN);
            else                        sum_in = SUM_W'(sum_add);
            cnt_in   = cnt_ff + 1'b1;
            state_in = last_ff ? S_MEAN : S_IDLE;
         end
         S_MEAN: begin
            neg_in = sum_ff[SUM_W-1];
            num_in = DVD_W'(sum_mag);
            den_in = DVS_W'(cnt_ff);
            if (cnt_ff == '0) begin
               n_in     = '0;
               rpow_in  = 32'h4000_0000;
               it_in    = '0;
               state_in = S_EXP;
            end else begin
               div_go_in = 1'b1;
               state_in  = S_MDIV;
            end
         end
         S_MDIV: begin
            if (div_stat.done) begin
               // mean log is negated: scale = key / 2^mean
               n_in     = neg_ff ? (SUM_W+1)'(quo[SUM_W-1:0])
                                 : -(SUM_W+1)'(quo[SUM_W-1:0]);
               rpow_in  = 32'h4000_0000;
               it_in    = '0;
               state_in = S_EXP;
            end
         end
         S_EXP: begin
            if (n_ff[IT_LAST - it_ff]) rpow_in = rmul[61:30];
            it_in = it_ff + 1'b1;
            if (it_ff == IT_LAST) state_in = S_KEY;
         end
         S_KEY: begin
            kprod_in = 48'(key_ff) * 48'(rpow_ff);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            if (kprod_ff == '0 || sh > (SUM_W+1)'(63)) scale_in = '0;
            else if (sh < 0)                           scale_in = '1;
            else if (shifted[47:32] != '0)             scale_in = '1;
            else                                       scale_in = shifted[31:0];
            sum_in   = '0;
            cnt_in   = '0;
            state_in = S_IDLE;
         end
         S_LO: begin
            lo_in    = lo_full[55:16];
            state_in = S_W2;
         end
         S_W2: begin
            w2_in     = (wsq[47:16] == '0) ? 32'd1 : wsq[47:16];
            num_in    = {8'd0, lo_ff, 16'd0};
            den_in    = DVS_W'(lo_ff) + DVS_W'(65536);
            div_go_in = 1'b1;
            state_in  = S_T1;
         end
         S_T1: begin
            if (div_stat.done) begin
               t1_in     = quo[15:0];
               den_in    = DVS_W'(w2_ff);
               div_go_in = 1'b1;
               state_in  = S_RAT;
            end
         end
         S_RAT: begin
            if (div_stat.done) begin
               ratio_in = (quo > RATIO_MAX) ? RATIO_MAX[LD_W-1:0] : quo[LD_W-1:0];
               state_in = S_LD;
            end
         end
         S_LD: begin
            ld_in      = ld_full[60:16];
            lane_go_in = 1'b1;
            state_in   = S_LANE;
         end
         S_LANE: begin
            if (lanes_done) begin
               res_in   = {lane_b.value, lane_g.value, lane_r.value};
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_go_ff    <= 1'b0;
         log_go_ff    <= 1'b0;
         lane_go_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         scale_ff     <= '0;
         key_ff       <= KEY_RESET;
         wp_ff        <= WHITE_RESET;
         boff_ff      <= BLACK_RESET;
      end else begin
         state_ff   <= state_in;
         div_go_ff  <= div_go_in;
         log_go_ff  <= log_go_in;
         lane_go_ff <= lane_go_in;
         sum_ff     <= sum_in;
         cnt_ff     <= cnt_in;
         scale_ff   <= scale_in;
         if (load_rsp)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_KEY:   key_ff  <= csr_wdata[KEY_W-1:0];
               CSR_WHITE: wp_ff   <= csr_wdata[WP_W-1:0];
               CSR_BLACK: boff_ff <= csr_wdata[BOFF_W-1:0];
               default:   ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         act_ff  <= req_tuser;
         last_ff <= req_tlast;
         r_ff    <= req_tdata[23:0];
         g_ff    <= req_tdata[47:24];
         b_ff    <= req_tdata[71:48];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      it_ff    <= it_in;
      lum_ff   <= lum_in;
      neg_ff   <= neg_in;
      n_ff     <= n_in;
      rpow_ff  <= rpow_in;
      kprod_ff <= kprod_in;
      lo_ff    <= lo_in;
      w2_ff    <= w2_in;
      t1_ff    <= t1_in;
      ratio_ff <= ratio_in;
      ld_ff    <= ld_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      res_ff   <= res_in;
   end

   // result register parts the two sides
   logic [47:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (load_rsp) rsp_data_ff <= res_ff;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/gtm_div.sv
// iterative restoring divider, one quotient bit per cycle
module gtm_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [gtm_pkg::DVD_W-1:0] dividend,
   input  logic [gtm_pkg::DVS_W-1:0] divisor,
   output gtm_pkg::unit_stat_type   stat,
   output logic [gtm_pkg::DVD_W-1:0] quotient
);
   import gtm_pkg::*;

   localparam int CW = $clog2(DVD_W);
   localparam logic [CW-1:0] CNT_LAST = CW'(DVD_W - 1);

   logic             busy_ff, done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DVS_W-1:0] rem_ff, dvs_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W:0]   shifted, diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_ff <= {quo_ff[DVD_W-2:0], ge};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

>>> sv/gtm_log.sv
// fixed point log2: normalize one bit a cycle, then one squaring per fraction bit
module gtm_log (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [gtm_pkg::LOGX_W-1:0]        x,
   output gtm_pkg::unit_stat_type            stat,
   output logic signed [gtm_pkg::LOG_W-1:0]  lg
);
   import gtm_pkg::*;

   typedef enum logic [2:0] {
      L_IDLE = 3'b001,
      L_NORM = 3'b010,
      L_SQ   = 3'b100
   } log_state_type;

   localparam logic [IT_W-1:0] IT_LAST = IT_W'(FRAC_BITS - 1);

   log_state_type        state_ff;
   logic                 done_ff;
   logic [30:0]          m_ff;
   logic [4:0]           p_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [IT_W-1:0]      it_ff;
   logic [61:0]          sq;
   logic [31:0]          sq_hi;
   logic [LOG_IW-1:0]    ipart;

   assign sq    = 62'(m_ff) * 62'(m_ff);
   assign sq_hi = sq[61:30];
   assign ipart = LOG_IW'({1'b0, p_ff}) - LOG_IW'(PIX_FRAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            L_IDLE: begin
               if (start) state_ff <= L_NORM;
            end
            L_NORM: begin
               if (m_ff[30]) state_ff <= L_SQ;
            end
            L_SQ: begin
               if (it_ff == IT_LAST) begin
                  state_ff <= L_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   // result stays on lg until the next start
   always_ff @(posedge clock) begin
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               m_ff    <= (x == '0) ? 31'd1 : 31'(x);
               p_ff    <= 5'd30;
               it_ff   <= '0;
               frac_ff <= '0;
            end
         end
         L_NORM: begin
            if (!m_ff[30]) begin
               m_ff <= {m_ff[29:0], 1'b0};
               p_ff <= p_ff - 1'b1;
            end
         end
         L_SQ: begin
            it_ff <= it_ff + 1'b1;
            if (sq_hi[31]) begin
               m_ff    <= sq_hi[31:1];
               frac_ff <= {frac_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               m_ff    <= sq_hi[30:0];
               frac_ff <= {frac_ff[FRAC_BITS-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   assign stat.busy = (state_ff != L_IDLE);
   assign stat.done = done_ff;
   assign lg        = $signed({ipart, frac_ff});

endmodule

>>> sv/gtm_lane.sv
// one colour lane: component times ld, divided by luminance, clamped
module gtm_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [gtm_pkg::PIX_W-1:0] comp,
   input  logic [gtm_pkg::LD_W-1:0]  ld,
   input  logic [gtm_pkg::LUM_W-1:0] lum,
   output gtm_pkg::lane_res_type     res
);
   import gtm_pkg::*;

   logic                 go_ff, done_ff;
   logic [OUT_W-1:0]     value_ff;
   logic [DVD_W-1:0]     prod_ff;
   unit_stat_type        div_stat;
   logic [DVD_W-1:0]     quo;

   gtm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .dividend (prod_ff),
      .divisor  (DVS_W'(lum)),
      .stat     (div_stat),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         go_ff <= 1'b0;
         if (start) begin
            done_ff <= (comp == '0) || ld[LD_W-1:LD_SAT] != '0;
            go_ff   <= (comp != '0) && ld[LD_W-1:LD_SAT] == '0;
         end else if (div_stat.done) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff  <= DVD_W'(comp) * DVD_W'(ld[LD_SAT-1:0]);
         value_ff <= (comp == '0) ? '0 : '1;
      end else if (div_stat.done) begin
         value_ff <= (quo[DVD_W-1:OUT_W] != '0) ? '1 : quo[OUT_W-1:0];
      end
   end

   assign res.done  = done_ff;
   assign res.value = value_ff;

endmodule

>>> sv/gtm_checker.sv
// port level checks for the tone mapper, bound to the top level
module gtm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [71:0]                req_tdata,
   input logic                       req_tuser,
   input logic                       req_tlast,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [47:0]                rsp_tdata,
   input logic                       csr_we,
   input logic [gtm_pkg::CSR_IW-1:0] csr_index,
   input logic [gtm_pkg::CSR_W-1:0]  csr_wdata
);

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one request in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // a measure request raises no result right after it is taken
   a_measure_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !$rose(rsp_tvalid))
      else $error("result after measure request");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind global_tone_mapper_unit gtm_checker u_gtm_checker (.*);

>>> dv/tb_global_tone_mapper_unit.sv
// testbench of the global tone mapper: directed cases and random two-pass frames checked against a local predictor
module tb_global_tone_mapper_unit;
   import gtm_pkg::*;

   typedef enum logic [1:0] {PIXEL_ENTRY, CSR_ENTRY, DRAIN_ENTRY} entry_kind_type;

   typedef struct packed {
      entry_kind_type    kind;
      logic              action;   // 0 measure, 1 map
      logic [23:0]       red;
      logic [23:0]       green;
      logic [23:0]       blue;
      logic              last;
      logic [CSR_IW-1:0] csr_sel;
      logic [CSR_W-1:0]  csr_val;
      logic              hold;     // receiver backs off once this request is taken
      logic              calm;     // no idling from here on
   } stim_entry_type;

   typedef struct packed {
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } rgb_out_type;

   localparam longint LOG_SUM_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint LOG_SUM_MIN = -LOG_SUM_MAX - 1;
   localparam int     SETTLE_CYCLES = 260;
   localparam int     HOLD_CYCLES   = 500;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [71:0]       req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [47:0]       rsp_tdata;
   logic              csr_we = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_W-1:0]  csr_wdata = '0;

   global_tone_mapper_unit uut (.*);

   // stimulus and prediction state
   stim_entry_type pending_stim[$];
   stim_entry_type cur_req;
   rgb_out_type    tone_expected[$];
   int          error_count = 0;
   int          pixel_total = 0;
   bit          req_taken = 0;
   bit          start_hold = 0;
   bit          calm_seen = 0;

   // predictor copy of the registers and the frame statistics
   logic [15:0] mdl_key;
   logic [23:0] mdl_white;
   logic [15:0] mdl_black;
   longint      mdl_log_sum;
   logic [31:0] mdl_count;
   logic [31:0] mdl_scale;

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] pixel_luma(logic [23:0] r, logic [23:0] g, logic [23:0] b);
      logic [63:0] s;
      s = 64'd19595 * r + 64'd38470 * g + 64'd7471 * b + 64'd32768;
      return s[47:16];
   endfunction

   // log2 in q.16: msb position plus 16 fraction bits by repeated squaring in q1.30
   function automatic longint log2_q16(logic [31:0] x);
      int          p;
      logic [63:0] m;
      longint      frac;
      p    = 0;
      frac = 0;
      if (x == 0) x = 1;
      for (int k = 31; k >= 0; k--) begin
         if (x[k]) begin
            p = k;
            break;
         end
      end
      m = (p <= 30) ? (64'(x) << (30 - p)) : (64'(x) >> 1);
      for (int k = 0; k < FRAC_BITS; k++) begin
         m    = (m * m) >> 30;
         frac = frac * 2;
         if (m >= 64'h8000_0000) begin
            frac = frac + 1;
            m    = m >> 1;
         end
      end
      return longint'(p - PIX_FRAC) * 65536 + frac;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bv;
      res = '0;
      bv  = 64'd1 << 62;
      while (bv > v) bv = bv >> 2;
      while (bv != 0) begin
         if (v >= res + bv) begin
            v   = v - (res + bv);
            res = (res >> 1) + bv;
         end else begin
            res = res >> 1;
         end
         bv = bv >> 2;
      end
      return res;
   endfunction

   // key / 2^(mean log), latched on the frame's last pixel
   function automatic void latch_frame_scale();
      logic [63:0] mag;
      logic [63:0] q;
      logic [63:0] f;
      logic [63:0] base;
      logic [63:0] pw;
      logic [63:0] prod;
      logic [63:0] v;
      longint      n;
      longint      ip;
      longint      sh;
      bit          neg;
      neg  = mdl_log_sum < 0;
      mag  = neg ? 64'(-mdl_log_sum) : 64'(mdl_log_sum);
      q    = (mdl_count != 0) ? mag / mdl_count : 64'd0;
      n    = neg ? longint'(q) : -longint'(q);
      if (n >= 0) begin
         ip = n / 65536;
         f  = 64'(n) & 64'hFFFF;
      end else begin
         ip = -longint'((64'(-n) + 64'hFFFF) >> 16);
         f  = 64'(n - ip * 65536);
      end
      base = 64'd1 << 31;
      pw   = 64'd1 << 30;
      for (int k = 1; k <= FRAC_BITS; k++) begin
         base = int_sqrt(base << 30);
         if (f[FRAC_BITS - k]) pw = (pw * base) >> 30;
      end
      prod = 64'(mdl_key) * pw;
      sh   = 30 - ip;
      if (prod == 0 || sh > 63) begin
         mdl_scale = '0;
      end else if (sh < 0) begin
         mdl_scale = 32'hFFFF_FFFF;
      end else begin
         v         = prod >> sh;
         mdl_scale = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      end
      mdl_log_sum = 0;
      mdl_count   = 0;
   endfunction

   function automatic logic [15:0] lane_value(logic [23:0] c, logic [63:0] ld, logic [31:0] lum);
      logic [63:0] v;
      if (c == 0) return 16'd0;
      if (ld >= (64'd1 << 40)) return 16'hFFFF;
      v = (64'(c) * ld) / lum;
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   // one accepted request: measure updates statistics, map queues a result
   function automatic void tone_step(stim_entry_type px);
      logic [31:0] lum;
      logic [63:0] lo;
      logic [63:0] t1;
      logic [63:0] w2;
      logic [63:0] ratio;
      logic [63:0] ld;
      longint      s;
      rgb_out_type res;
      lum = pixel_luma(px.red, px.green, px.blue);
      if (!px.action) begin
         if (mdl_count < (32'd1 << MAX_PIXELS_LOG2)) begin
            s = mdl_log_sum + log2_q16(lum + mdl_black);
            if (s > LOG_SUM_MAX) s = LOG_SUM_MAX;
            if (s < LOG_SUM_MIN) s = LOG_SUM_MIN;
            mdl_log_sum = s;
            mdl_count   = mdl_count + 1;
         end
         if (px.last) latch_frame_scale();
         return;
      end
      res = '0;
      if (lum != 0) begin
         lo    = (64'(mdl_scale) * lum) >> 16;
         t1    = (lo << 16) / (lo + 64'd65536);
         w2    = (64'(mdl_white) * mdl_white) >> 16;
         if (w2 == 0) w2 = 1;
         ratio = (lo << 16) / w2;
         if (ratio > (64'd1 << 44)) ratio = 64'd1 << 44;
         ld        = (t1 * (64'd65536 + ratio)) >> 16;
         res.red   = lane_value(px.red, ld, lum);
         res.green = lane_value(px.green, ld, lum);
         res.blue  = lane_value(px.blue, ld, lum);
      end
      tone_expected.push_back(res);
   endfunction

   // ---------------------------------------------------------------- stimulus build

   function automatic void add_pixel(logic act, logic [23:0] r, logic [23:0] g,
                                     logic [23:0] b, logic lst, logic hld = 0, logic clm = 0);
      stim_entry_type e;
      e        = '0;
      e.kind   = PIXEL_ENTRY;
      e.action = act;
      e.red    = r;
      e.green  = g;
      e.blue   = b;
      e.last   = lst;
      e.hold   = hld;
      e.calm   = clm;
      pending_stim.push_back(e);
      pixel_total++;
   endfunction

   function automatic void add_csr(logic [CSR_IW-1:0] sel, logic [CSR_W-1:0] val);
      stim_entry_type e;
      e         = '0;
      e.kind    = CSR_ENTRY;
      e.csr_sel = sel;
      e.csr_val = val;
      pending_stim.push_back(e);
   endfunction

   function automatic void add_drain();
      stim_entry_type e;
      e      = '0;
      e.kind = DRAIN_ENTRY;
      pending_stim.push_back(e);
   endfunction

   // colour component spread over zero, tiny, unit range, up to eight, full range and max
   function automatic logic [23:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(0, 255));
         3: return 24'($urandom_range(0, 65535));
         4: return 24'($urandom_range(0, 524288));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic void random_config();
      add_drain();
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 3))
            0: add_csr(CSR_KEY, 24'd0);
            1: add_csr(CSR_KEY, 24'd65535);
            default: add_csr(CSR_KEY, 24'($urandom_range(0, 65535)));
         endcase
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 4))
            0: add_csr(CSR_WHITE, 24'd1);
            1: add_csr(CSR_WHITE, 24'hFFFFFF);
            2: add_csr(CSR_WHITE, 24'($urandom_range(1, 24'hFFFFFF)));
            default: add_csr(CSR_WHITE, 24'($urandom_range(20000, 400000)));
         endcase
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 3))
            0: add_csr(CSR_BLACK, 24'd1);
            1: add_csr(CSR_BLACK, 24'd65535);
            default: add_csr(CSR_BLACK, 24'($urandom_range(1, 65535)));
         endcase
      end
   endfunction

   function automatic void build_stimulus();
      int n_meas;
      int n_map;
      int phase;
      bit clm;
      // directed: nothing measured yet, so every mapped pixel is black
      add_pixel(1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0);
      add_pixel(1, 24'd0, 24'd0, 24'd0, 0);
      // default registers, a short frame, then zero, single-lane and max pixels
      add_pixel(0, 24'd65536, 24'd65536, 24'd65536, 0);
      add_pixel(0, 24'd13107, 24'd0, 24'd200000, 1);
      add_pixel(1, 24'd0, 24'd0, 24'd0, 0);
      add_pixel(1, 24'd65536, 24'd0, 24'd0, 1);     // last on a map pixel is ignored
      add_pixel(1, 24'd0, 24'd0, 24'd65536, 0);
      add_pixel(1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0);
      add_pixel(1, 24'd1, 24'd2, 24'd3, 0);
      // black frame with smallest offset: scale comes just under its limit, ld goes huge
      add_drain();
      add_csr(CSR_KEY, 24'd65535);
      add_csr(CSR_WHITE, 24'hFFFFFF);
      add_csr(CSR_BLACK, 24'd1);
      add_pixel(0, 24'd0, 24'd0, 24'd0, 0);
      add_pixel(0, 24'd0, 24'd0, 24'd0, 1);
      add_pixel(1, 24'hFFFFFF, 24'd0, 24'd1, 0);
      add_pixel(1, 24'd1, 24'd1, 24'd1, 0);
      // tiny white point with a bright frame
      add_drain();
      add_csr(CSR_WHITE, 24'd1);
      add_csr(CSR_BLACK, 24'd65535);
      add_pixel(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1);
      add_pixel(1, 24'd70000, 24'd3000, 24'd0, 0);
      // zero key: scale drops to zero
      add_drain();
      add_csr(CSR_KEY, 24'd0);
      add_pixel(0, 24'd1000, 24'd1000, 24'd1000, 1);
      add_pixel(1, 24'd65536, 24'd65536, 24'd65536, 0);
      // back to defaults
      add_drain();
      add_csr(CSR_KEY, 24'(KEY_RESET));
      add_csr(CSR_WHITE, 24'(WHITE_RESET));
      add_csr(CSR_BLACK, 24'(BLACK_RESET));

      phase = 0;
      while (pixel_total < 600) begin
         clm = pixel_total > 540;
         if (phase % 3 == 2) random_config();
         else if (phase == 4) add_drain();   // sender waits for every result
         n_meas = $urandom_range(1, 12);
         for (int i = 0; i < n_meas; i++)
            add_pixel(0, rand_comp(), rand_comp(), rand_comp(), i == n_meas - 1, 0, clm);
         n_map = $urandom_range(2, 14);
         for (int i = 0; i < n_map; i++)
            add_pixel(1, rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 7) == 0,
                      phase == 6 && i == 0, clm);
         // occasional stray measure pixel left open into the next frame
         if ($urandom_range(0, 4) == 0)
            add_pixel(0, rand_comp(), rand_comp(), rand_comp(), 0, 0, clm);
         phase++;
      end
   endfunction

   // ---------------------------------------------------------------- reset and run

   initial begin
      build_stimulus();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // sender: drive requests and register writes at the falling edge
   always @(negedge clock) begin
      stim_entry_type head;
      logic        nxt_valid;
      logic        nxt_we;
      int          gap_left;
      int          settle;
      nxt_valid = req_tvalid && !req_taken;
      nxt_we    = 1'b0;
      req_taken = 0;
      if (!reset && !nxt_valid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_stim.size() > 0) begin
            head = pending_stim[0];
            case (head.kind)
               PIXEL_ENTRY: begin
                  cur_req = head;
                  req_tdata <= {head.blue, head.green, head.red};
                  req_tuser <= head.action;
                  req_tlast <= head.last;
                  nxt_valid = 1'b1;
                  void'(pending_stim.pop_front());
                  if (!head.calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
               end
               CSR_ENTRY: begin
                  csr_index <= head.csr_sel;
                  csr_wdata <= head.csr_val;
                  nxt_we = 1'b1;
                  void'(pending_stim.pop_front());
               end
               default: begin
                  // idle until all results are back and the block has settled
                  if (tone_expected.size() == 0) begin
                     if (settle < SETTLE_CYCLES) settle++;
                     else begin
                        settle = 0;
                        void'(pending_stim.pop_front());
                     end
                  end
               end
            endcase
         end
      end
      req_tvalid <= nxt_valid;
      csr_we     <= nxt_we;
   end

   // receiver: random stall bursts plus one long hold-off
   always @(negedge clock) begin
      int stall_left;
      int hold_left;
      logic rdy;
      rdy = 1'b1;
      if (start_hold) begin
         start_hold = 0;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rdy = 1'b0;
      end else if (!calm_seen && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 3);
         rdy        = 1'b0;
      end
      rsp_tready <= reset ? 1'b0 : rdy;
   end

   // monitor: register writes, accepted requests and results at the rising edge
   always @(posedge clock) begin
      rgb_out_type want;
      rgb_out_type got;
      if (reset) begin
         mdl_key     = KEY_RESET;
         mdl_white   = WHITE_RESET;
         mdl_black   = BLACK_RESET;
         mdl_log_sum = 0;
         mdl_count   = 0;
         mdl_scale   = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KEY:   mdl_key   = csr_wdata[15:0];
               CSR_WHITE: mdl_white = csr_wdata[23:0];
               CSR_BLACK: mdl_black = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1;
            if (cur_req.hold) start_hold = 1;
            if (cur_req.calm) calm_seen = 1;
            tone_step(cur_req);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (tone_expected.size() == 0) begin
               $error("unexpected result %h", rsp_tdata);
               error_count++;
            end else begin
               want = tone_expected.pop_front();
               if (got.red !== want.red) begin
                  $error("red_out expected %0d actual %0d", want.red, got.red);
                  error_count++;
               end
               if (got.green !== want.green) begin
                  $error("green_out expected %0d actual %0d", want.green, got.green);
                  error_count++;
               end
               if (got.blue !== want.blue) begin
                  $error("blue_out expected %0d actual %0d", want.blue, got.blue);
                  error_count++;
               end
            end
         end
      end
   end

   // end of run: everything sent, every result back, then let the block settle
   initial begin
      @(negedge reset);
      do @(posedge clock);
      while (pending_stim.size() != 0 || req_tvalid || tone_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tone_expected.size() != 0) begin
         $error("%0d results never arrived", tone_expected.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
sv/gtm_pkg.sv
sv/gtm_div.sv
sv/gtm_log.sv
sv/gtm_lane.sv
sv/global_tone_mapper_unit.sv
sv/gtm_checker.sv
dv/tb_global_tone_mapper_unit.sv
